/* sv/int64_divide_modulo_top_assert.svh */
// ----------------------------------------------------------------------------
// int64_divide_modulo_top_assert.svh
// Assertion macros used by the divider top. They sample on clk and are
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INT64_DIVIDE_MODULO_TOP_ASSERT_SVH
`define INT64_DIVIDE_MODULO_TOP_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define I64DM_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define I64DM_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* sv/i64dm_pkg.sv */
// ----------------------------------------------------------------------------
// i64dm_pkg
// Field widths, command codes and the per-item control bundle of the divider.
// ----------------------------------------------------------------------------
package i64dm_pkg;

  localparam int FIELD_W = 64;
  localparam int CMD_W   = 2;

  localparam logic [CMD_W-1:0] CMD_UDIV = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SDIV = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UREM = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SREM = 2'd3;

  // Control bits that ride along with each beat through the pipeline.
  typedef struct packed {
    logic is_rem;    // deliver remainder instead of quotient
    logic neg;       // negate the selected magnitude at the end
    logic zero_div;  // divisor was zero: quotient forced to zero
  } ctl_t;

endpackage

/* sv/i64dm_if.sv */
// ----------------------------------------------------------------------------
// i64dm_if
// Valid/ready channels of the divider: command and operands in, result out.
// ----------------------------------------------------------------------------
interface i64dm_in_if import i64dm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [FIELD_W-1:0] dividend;
  logic [FIELD_W-1:0] divisor;

  modport source (output valid, output cmd, output dividend, output divisor, input ready);
  modport sink   (input valid, input cmd, input dividend, input divisor, output ready);
endinterface

interface i64dm_out_if import i64dm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

/* sv/i64dm_prep.sv */
// ----------------------------------------------------------------------------
// i64dm_prep
// Input stage: decode the command, take operand magnitudes, flag a zero
// divisor and register the beat.
// ----------------------------------------------------------------------------
module i64dm_prep import i64dm_pkg::*; #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  logic [CMD_W-1:0]        up_cmd,
  input  logic [FIELD_W-1:0]      up_dividend,
  input  logic [FIELD_W-1:0]      up_divisor,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output logic [2*DATA_WIDTH-1:0] dn_rq,
  output logic [DATA_WIDTH-1:0]   dn_den,
  output ctl_t                    dn_ctl
);

  logic                  valid_r;
  logic [DATA_WIDTH-1:0] mag_a_r, mag_a_nxt;
  logic [DATA_WIDTH-1:0] den_r, den_nxt;
  ctl_t                  ctl_r, ctl_nxt;
  logic [DATA_WIDTH-1:0] a, b;
  logic                  is_signed, is_rem, a_neg, b_neg;

  assign a = up_dividend[DATA_WIDTH-1:0];
  assign b = up_divisor[DATA_WIDTH-1:0];

  always_comb begin
    case (up_cmd)
      CMD_UDIV: begin is_signed = 1'b0; is_rem = 1'b0; end
      CMD_SDIV: begin is_signed = 1'b1; is_rem = 1'b0; end
      CMD_UREM: begin is_signed = 1'b0; is_rem = 1'b1; end
      CMD_SREM: begin is_signed = 1'b1; is_rem = 1'b1; end
      default:  begin is_signed = 1'b0; is_rem = 1'b0; end
    endcase
  end

  always_comb begin
    a_neg            = is_signed & a[DATA_WIDTH-1];
    b_neg            = is_signed & b[DATA_WIDTH-1];
    mag_a_nxt        = a_neg ? (~a + 1'b1) : a;
    den_nxt          = b_neg ? (~b + 1'b1) : b;
    ctl_nxt.is_rem   = is_rem;
    // Remainder takes the dividend's sign, quotient the sign product.
    ctl_nxt.neg      = is_rem ? a_neg : (a_neg ^ b_neg);
    ctl_nxt.zero_div = (b == '0);
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      mag_a_r <= mag_a_nxt;
      den_r   <= den_nxt;
      ctl_r   <= ctl_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_rq    = {{DATA_WIDTH{1'b0}}, mag_a_r};
  assign dn_den   = den_r;
  assign dn_ctl   = ctl_r;

endmodule

/* sv/i64dm_step.sv */
// ----------------------------------------------------------------------------
// i64dm_step
// One restoring division step: shift the next dividend bit into the partial
// remainder, trial-subtract the divisor, keep the quotient bit.
// ----------------------------------------------------------------------------
module i64dm_step import i64dm_pkg::*; #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  logic [2*DATA_WIDTH-1:0] up_rq,
  input  logic [DATA_WIDTH-1:0]   up_den,
  input  ctl_t                    up_ctl,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output logic [2*DATA_WIDTH-1:0] dn_rq,
  output logic [DATA_WIDTH-1:0]   dn_den,
  output ctl_t                    dn_ctl
);

  logic                    valid_r;
  logic [2*DATA_WIDTH-1:0] rq_r, rq_nxt;
  logic [DATA_WIDTH-1:0]   den_r;
  ctl_t                    ctl_r;
  logic [DATA_WIDTH:0]     shifted, diff;
  logic                    ge;
  logic [DATA_WIDTH-1:0]   rem_nxt;

  // Upper half holds the partial remainder, lower half the unused dividend
  // bits with quotient bits filling in from the bottom.
  always_comb begin
    shifted = {up_rq[2*DATA_WIDTH-1:DATA_WIDTH], up_rq[DATA_WIDTH-1]};
    diff    = shifted - {1'b0, up_den};
    ge      = !diff[DATA_WIDTH];
    rem_nxt = ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
    rq_nxt  = {rem_nxt, up_rq[DATA_WIDTH-2:0], ge};
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      rq_r  <= rq_nxt;
      den_r <= up_den;
      ctl_r <= up_ctl;
    end
  end

  assign dn_valid = valid_r;
  assign dn_rq    = rq_r;
  assign dn_den   = den_r;
  assign dn_ctl   = ctl_r;

endmodule

/* sv/i64dm_post.sv */
// ----------------------------------------------------------------------------
// i64dm_post
// Output stage: pick quotient or remainder, apply the sign, hold the result
// beat until the sink takes it.
// ----------------------------------------------------------------------------
module i64dm_post import i64dm_pkg::*; #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  logic [2*DATA_WIDTH-1:0] up_rq,
  input  ctl_t                    up_ctl,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output logic [FIELD_W-1:0]      dn_result
);

  logic                  valid_r;
  logic [DATA_WIDTH-1:0] res_r, res_nxt;
  logic [DATA_WIDTH-1:0] quot, mag;

  // A zero divisor leaves the dividend magnitude as remainder and all ones
  // as quotient; force the quotient to zero.
  always_comb begin
    quot    = up_ctl.zero_div ? '0 : up_rq[DATA_WIDTH-1:0];
    mag     = up_ctl.is_rem ? up_rq[2*DATA_WIDTH-1:DATA_WIDTH] : quot;
    res_nxt = up_ctl.neg ? (~mag + 1'b1) : mag;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      res_r <= res_nxt;
    end
  end

  assign dn_valid  = valid_r;
  assign dn_result = FIELD_W'(res_r);

endmodule

/* sv/int64_divide_modulo_top.sv */
// ----------------------------------------------------------------------------
// int64_divide_modulo_top: pipelined restoring divider with quotient/remainder.
// Path: prep register, one step register per quotient bit, post register.
// Throughput: one beat per cycle unless the output stalls; one step per stage.
// Reset: synchronous rst_n clears all stage valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module int64_divide_modulo_top import i64dm_pkg::*; #(
  parameter int DATA_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  i64dm_in_if.sink    in_ch,
  i64dm_out_if.source out_ch
);

`include "int64_divide_modulo_top_assert.svh"

  // Pipeline depth in stages: prep, one per quotient bit, post.
  localparam int DEPTH = DATA_WIDTH + 2;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Stage links. Index 0 is the prep output, index k+1 the output of step k.
  logic [DATA_WIDTH:0]     stg_valid;
  logic [DATA_WIDTH:0]     stg_ready;
  logic [2*DATA_WIDTH-1:0] stg_rq  [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0]   stg_den [DATA_WIDTH+1];
  ctl_t                    stg_ctl [DATA_WIDTH+1];

  // Decode and take magnitudes. Each stage is ready when empty or when its
  // successor takes the held beat, so bubbles collapse and stalls lose nothing.
  i64dm_prep #(.DATA_WIDTH(DATA_WIDTH)) u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (in_ch.valid),
    .up_ready    (in_ch.ready),
    .up_cmd      (in_ch.cmd),
    .up_dividend (in_ch.dividend),
    .up_divisor  (in_ch.divisor),
    .dn_valid    (stg_valid[0]),
    .dn_ready    (stg_ready[0]),
    .dn_rq       (stg_rq[0]),
    .dn_den      (stg_den[0]),
    .dn_ctl      (stg_ctl[0])
  );

  // One quotient bit per stage, from the top bit down.
  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
    i64dm_step #(.DATA_WIDTH(DATA_WIDTH)) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[k]),
      .up_ready (stg_ready[k]),
      .up_rq    (stg_rq[k]),
      .up_den   (stg_den[k]),
      .up_ctl   (stg_ctl[k]),
      .dn_valid (stg_valid[k+1]),
      .dn_ready (stg_ready[k+1]),
      .dn_rq    (stg_rq[k+1]),
      .dn_den   (stg_den[k+1]),
      .dn_ctl   (stg_ctl[k+1])
    );
  end

  // Select and sign-fix the result; this register holds the result beat, and
  // while it waits new beats enter only until the stages ahead of it fill.
  i64dm_post #(.DATA_WIDTH(DATA_WIDTH)) u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (stg_valid[DATA_WIDTH]),
    .up_ready  (stg_ready[DATA_WIDTH]),
    .up_rq     (stg_rq[DATA_WIDTH]),
    .up_ctl    (stg_ctl[DATA_WIDTH]),
    .dn_valid  (out_ch.valid),
    .dn_ready  (out_ch.ready),
    .dn_result (out_ch.result)
  );

  // Track beats in flight for the checks below.
  logic             in_beat, out_beat;
  logic [CNT_W-1:0] inflight_r, inflight_nxt;

  assign in_beat      = in_ch.valid && in_ch.ready;
  assign out_beat     = out_ch.valid && out_ch.ready;
  assign inflight_nxt = inflight_r + CNT_W'(in_beat) - CNT_W'(out_beat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  `I64DM_ASSERT_ALWAYS(a_inflight_bound, inflight_r <= CNT_W'(DEPTH), "more beats in flight than stages")
  `I64DM_ASSERT_IMPLIES(a_empty_no_out, inflight_r == '0, !out_ch.valid, "result beat from an empty pipeline")
  `I64DM_ASSERT_IMPLIES(a_full_stall, (inflight_r == CNT_W'(DEPTH)) && !out_ch.ready, !in_ch.ready, "input taken while pipeline full and stalled")

endmodule
